// File: rtl/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// Shared constants, codes and ALU request/response types for the chunked
// descriptor allocator.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int SLOTS_PER_CHUNK = 64;
  localparam int MAX_CHUNKS      = 256;
  localparam int SLOT_LOG2       = $clog2(SLOTS_PER_CHUNK);

  localparam int ID_W     = 8;    // chunk id
  localparam int CNT_W    = 9;    // chunk counts: total, carved, run size, free level
  localparam int COUNT_W  = 15;   // slot counts and fill
  localparam int BASE_W   = 14;   // base index
  localparam int USERS_W  = 16;   // per-chunk user count
  localparam int NEED_W   = COUNT_W - SLOT_LOG2 + 1;  // chunks needed by a request
  localparam int SUM_W    = NEED_W + 1;               // carved + need
  localparam int ALU_W    = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [USERS_W-1:0] USERS_MAX = '1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FAIL     = 2'd1,
    STATUS_NO_USERS = 2'd2
  } status_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;   // a >= b, unsigned
  } alu_rsp_t;

endpackage
`default_nettype wire

// File: rtl/chunked_descriptor_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Path (acceptance to out_tvalid): release runs S_R_CHECK then S_OUT; allocate runs
//   further states per fallback: fits current run, empty run reused, freed chunk, carved.
// Throughput: one transaction at a time; the next is accepted the cycle after the
//   result enters the output register; S_OUT waits while that register is full and out_tready is low.
// Reset (rst_n low, synchronous): empty heap, no current run, free FIFO empty,
//   all user counts zero (valid bits), total_chunks = 256.
// ----------------------------------------------------------------------------
// chunked_descriptor_allocator
// Chunked bump allocator with a FIFO of freed chunks. A small sequencer runs
// each request through a shared add/compare unit, state by state.
// ----------------------------------------------------------------------------
module chunked_descriptor_allocator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [cda_pkg::IN_DATA_W-1:0]    in_tdata,   // [14:0] desc_count, [22:15] release_chunk
  input  wire logic [0:0]                       in_tuser,   // [0] opcode
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [cda_pkg::OUT_DATA_W-1:0]   out_tdata,  // [13:0] base_index, [21:14] chunk_id
  output logic      [1:0]                       out_tuser,  // [1:0] status
  // total_chunks register write
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cda_pkg::CNT_W-1:0]        cfg_data
);
  import cda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_ROOM,    // room = capacity - fill
    S_A_FIT,     // room >= count: bump in current run
    S_A_REUSE,   // empty current run large enough: restart it
    S_A_NEED,    // chunks needed = ceil(count / slots)
    S_A_SUM,     // carved + need
    S_A_LIMIT,   // carved + need <= heap limit
    S_A_UWAIT,   // user count of freshly carved chunk
    S_A_POP1,    // free FIFO head arrives
    S_A_POP2,    // span and users of popped chunk arrive
    S_A_CHECK,   // user count saturation, count + 1 written back
    S_A_BASE,    // base index
    S_A_COMMIT,  // new fill, current run, carve / pop bookkeeping
    S_R_CHECK,   // release: count - 1, free FIFO push
    S_OUT        // hand result to output register
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [ID_W-1:0]     cur_start_r, cur_start_nxt;
  logic [CNT_W-1:0]    cur_size_r, cur_size_nxt;
  logic [COUNT_W-1:0]  cur_fill_r, cur_fill_nxt;
  logic [CNT_W-1:0]    carved_r, carved_nxt;
  logic [ID_W-1:0]     head_r, head_nxt;
  logic [ID_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]    level_r, level_nxt;

  // per-request working registers (payload)
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [ID_W-1:0]     rel_r, rel_nxt;
  logic [COUNT_W-1:0]  room_r, room_nxt;
  logic [USERS_W-1:0]  usr_cur_r, usr_cur_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ID_W-1:0]     cand_start_r, cand_start_nxt;
  logic [CNT_W-1:0]    cand_size_r, cand_size_nxt;
  logic [COUNT_W-1:0]  cand_fill_r, cand_fill_nxt;
  logic [USERS_W-1:0]  cand_users_r, cand_users_nxt;
  logic                cand_pop_r, cand_pop_nxt;
  logic                cand_carve_r, cand_carve_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [BASE_W-1:0]   res_base_r, res_base_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [BASE_W-1:0]   out_base_r, out_base_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;

  // user-count valid bits: an entry never written reads as zero
  logic [MAX_CHUNKS-1:0] users_vld_r;
  logic                  vld_q_r;

  // --------------------------------------------------------------------------
  // Memories and shared ALU
  // --------------------------------------------------------------------------
  logic                users_we;
  logic [ID_W-1:0]     users_waddr;
  logic [USERS_W-1:0]  users_wdata;
  logic [ID_W-1:0]     users_raddr;
  logic [USERS_W-1:0]  users_rdata;
  logic [USERS_W-1:0]  users_q;

  logic                span_we;
  logic [ID_W-1:0]     span_waddr;
  logic [CNT_W-1:0]    span_wdata;
  logic [CNT_W-1:0]    span_rdata;

  logic                fifo_we;
  logic [ID_W-1:0]     fifo_rdata;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  cda_ram #(.WIDTH(USERS_W), .DEPTH(MAX_CHUNKS)) u_users_ram (
    .clk   (clk),
    .we    (users_we),
    .waddr (users_waddr),
    .wdata (users_wdata),
    .raddr (users_raddr),
    .rdata (users_rdata)
  );

  // run length per start chunk; read address follows the free FIFO head data
  cda_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CHUNKS)) u_span_ram (
    .clk   (clk),
    .we    (span_we),
    .waddr (span_waddr),
    .wdata (span_wdata),
    .raddr (fifo_rdata),
    .rdata (span_rdata)
  );

  // free chunk FIFO storage, read at head every cycle
  cda_ram #(.WIDTH(ID_W), .DEPTH(MAX_CHUNKS)) u_free_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail_r),
    .wdata (rel_r),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  cda_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic               in_fire;
  logic               out_free;
  logic [CNT_W-1:0]   limit;
  logic [ALU_W-1:0]   cap;
  logic [NEED_W-1:0]  need_c;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign cfg_ready = 1'b1;

  assign limit   = (total_r > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : total_r;
  assign cap     = ALU_W'(cur_size_r) << SLOT_LOG2;
  assign users_q = vld_q_r ? users_rdata : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - BASE_W - ID_W)'(0), out_id_r, out_base_r};
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // Sequencer next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    total_nxt      = cfg_valid ? cfg_data : total_r;
    cur_valid_nxt  = cur_valid_r;
    cur_start_nxt  = cur_start_r;
    cur_size_nxt   = cur_size_r;
    cur_fill_nxt   = cur_fill_r;
    carved_nxt     = carved_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    level_nxt      = level_r;
    count_nxt      = count_r;
    rel_nxt        = rel_r;
    room_nxt       = room_r;
    usr_cur_nxt    = usr_cur_r;
    need_nxt       = need_r;
    sum_nxt        = sum_r;
    cand_start_nxt = cand_start_r;
    cand_size_nxt  = cand_size_r;
    cand_fill_nxt  = cand_fill_r;
    cand_users_nxt = cand_users_r;
    cand_pop_nxt   = cand_pop_r;
    cand_carve_nxt = cand_carve_r;
    res_status_nxt = res_status_r;
    res_base_nxt   = res_base_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_id_nxt     = out_id_r;

    users_raddr = cur_start_r;
    users_we    = 1'b0;
    users_waddr = cand_start_r;
    users_wdata = alu_rsp.res;
    span_we     = 1'b0;
    span_waddr  = carved_r[ID_W-1:0];
    span_wdata  = need_r[CNT_W-1:0];
    fifo_we     = 1'b0;

    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;

    need_c = NEED_W'(alu_rsp.res >> SLOT_LOG2);
    if (need_c == '0) begin
      need_c = NEED_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          count_nxt = in_tdata[COUNT_W-1:0];
          rel_nxt   = in_tdata[COUNT_W +: ID_W];
          if (in_tuser[0] == OP_RELEASE) begin
            users_raddr = in_tdata[COUNT_W +: ID_W];
            state_nxt   = S_R_CHECK;
          end else begin
            state_nxt = S_A_ROOM;
          end
        end
      end

      S_A_ROOM: begin
        alu_req.a   = cap;
        alu_req.b   = ALU_W'(cur_fill_r);
        alu_req.sub = 1'b1;
        room_nxt    = alu_rsp.res[COUNT_W-1:0];
        usr_cur_nxt = users_q;
        state_nxt   = S_A_FIT;
      end

      S_A_FIT: begin
        alu_req.a   = ALU_W'(room_r);
        alu_req.b   = ALU_W'(count_r);
        alu_req.sub = 1'b1;
        if (cur_valid_r && alu_rsp.ge) begin
          cand_start_nxt = cur_start_r;
          cand_size_nxt  = cur_size_r;
          cand_fill_nxt  = cur_fill_r;
          cand_users_nxt = usr_cur_r;
          cand_pop_nxt   = 1'b0;
          cand_carve_nxt = 1'b0;
          state_nxt      = S_A_CHECK;
        end else begin
          state_nxt = S_A_REUSE;
        end
      end

      S_A_REUSE: begin
        alu_req.a   = cap;
        alu_req.b   = ALU_W'(count_r);
        alu_req.sub = 1'b1;
        if (cur_valid_r && usr_cur_r == '0 && alu_rsp.ge) begin
          cand_start_nxt = cur_start_r;
          cand_size_nxt  = cur_size_r;
          cand_fill_nxt  = '0;
          cand_users_nxt = usr_cur_r;
          cand_pop_nxt   = 1'b0;
          cand_carve_nxt = 1'b0;
          state_nxt      = S_A_CHECK;
        end else begin
          state_nxt = S_A_NEED;
        end
      end

      S_A_NEED: begin
        alu_req.a = ALU_W'(count_r);
        alu_req.b = ALU_W'(SLOTS_PER_CHUNK - 1);
        need_nxt  = need_c;
        // single-chunk request prefers a freed chunk; FIFO head is read now
        if (need_c == NEED_W'(1) && level_r != '0) begin
          state_nxt = S_A_POP1;
        end else begin
          state_nxt = S_A_SUM;
        end
      end

      S_A_SUM: begin
        alu_req.a = ALU_W'(carved_r);
        alu_req.b = ALU_W'(need_r);
        sum_nxt   = alu_rsp.res[SUM_W-1:0];
        state_nxt = S_A_LIMIT;
      end

      S_A_LIMIT: begin
        alu_req.a   = ALU_W'(limit);
        alu_req.b   = ALU_W'(sum_r);
        alu_req.sub = 1'b1;
        if (alu_rsp.ge) begin
          users_raddr    = carved_r[ID_W-1:0];
          cand_start_nxt = carved_r[ID_W-1:0];
          cand_size_nxt  = need_r[CNT_W-1:0];
          cand_fill_nxt  = '0;
          cand_pop_nxt   = 1'b0;
          cand_carve_nxt = 1'b1;
          state_nxt      = S_A_UWAIT;
        end else begin
          res_status_nxt = STATUS_FAIL;
          res_base_nxt   = '0;
          res_id_nxt     = '0;
          state_nxt      = S_OUT;
        end
      end

      S_A_UWAIT: begin
        cand_users_nxt = users_q;
        state_nxt      = S_A_CHECK;
      end

      S_A_POP1: begin
        users_raddr    = fifo_rdata;
        cand_start_nxt = fifo_rdata;
        state_nxt      = S_A_POP2;
      end

      S_A_POP2: begin
        cand_size_nxt  = span_rdata;
        cand_users_nxt = users_q;
        cand_fill_nxt  = '0;
        cand_pop_nxt   = 1'b1;
        cand_carve_nxt = 1'b0;
        state_nxt      = S_A_CHECK;
      end

      S_A_CHECK: begin
        alu_req.a = cand_users_r;
        alu_req.b = ALU_W'(1);
        if (cand_users_r == USERS_MAX) begin
          // saturated user count: fail, nothing committed
          res_status_nxt = STATUS_FAIL;
          res_base_nxt   = '0;
          res_id_nxt     = '0;
          state_nxt      = S_OUT;
        end else begin
          users_we  = 1'b1;
          state_nxt = S_A_BASE;
        end
      end

      S_A_BASE: begin
        alu_req.a      = ALU_W'(cand_start_r) << SLOT_LOG2;
        alu_req.b      = ALU_W'(cand_fill_r);
        res_status_nxt = STATUS_OK;
        res_base_nxt   = alu_rsp.res[BASE_W-1:0];
        res_id_nxt     = cand_start_r;
        state_nxt      = S_A_COMMIT;
      end

      S_A_COMMIT: begin
        alu_req.a     = ALU_W'(cand_fill_r);
        alu_req.b     = ALU_W'(count_r);
        cur_fill_nxt  = alu_rsp.res[COUNT_W-1:0];
        cur_valid_nxt = 1'b1;
        cur_start_nxt = cand_start_r;
        cur_size_nxt  = cand_size_r;
        if (cand_carve_r) begin
          carved_nxt = sum_r[CNT_W-1:0];
          span_we    = 1'b1;
        end
        if (cand_pop_r) begin
          head_nxt  = head_r + ID_W'(1);
          level_nxt = level_r - CNT_W'(1);
        end
        state_nxt = S_OUT;
      end

      S_R_CHECK: begin
        alu_req.a      = users_q;
        alu_req.b      = ALU_W'(1);
        alu_req.sub    = 1'b1;
        users_waddr    = rel_r;
        res_base_nxt   = '0;
        res_id_nxt     = rel_r;
        if (users_q == '0) begin
          res_status_nxt = STATUS_NO_USERS;
        end else begin
          res_status_nxt = STATUS_OK;
          users_we       = 1'b1;
          // last user gone on a chunk that is not current: queue it as free if the FIFO has room
          if (alu_rsp.res == '0 && !(cur_valid_r && cur_start_r == rel_r) &&
              level_r != CNT_W'(MAX_CHUNKS)) begin
            fifo_we   = 1'b1;
            tail_nxt  = tail_r + ID_W'(1);
            level_nxt = level_r + CNT_W'(1);
          end
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_base_nxt   = res_base_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= CNT_W'(MAX_CHUNKS);
      cur_valid_r <= 1'b0;
      cur_start_r <= '0;
      cur_size_r  <= '0;
      cur_fill_r  <= '0;
      carved_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
      users_vld_r <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_start_r <= cur_start_nxt;
      cur_size_r  <= cur_size_nxt;
      cur_fill_r  <= cur_fill_nxt;
      carved_r    <= carved_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (users_we) begin
        users_vld_r[users_waddr] <= 1'b1;
      end
    end
    vld_q_r      <= users_vld_r[users_raddr];
    count_r      <= count_nxt;
    rel_r        <= rel_nxt;
    room_r       <= room_nxt;
    usr_cur_r    <= usr_cur_nxt;
    need_r       <= need_nxt;
    sum_r        <= sum_nxt;
    cand_start_r <= cand_start_nxt;
    cand_size_r  <= cand_size_nxt;
    cand_fill_r  <= cand_fill_nxt;
    cand_users_r <= cand_users_nxt;
    cand_pop_r   <= cand_pop_nxt;
    cand_carve_r <= cand_carve_nxt;
    res_status_r <= res_status_nxt;
    res_base_r   <= res_base_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/cda_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/cda_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_alu
// Shared add/subtract unit with unsigned greater-or-equal flag.
// ----------------------------------------------------------------------------
module cda_alu (
  input  wire cda_pkg::alu_req_t req,
  output cda_pkg::alu_rsp_t      rsp
);
  import cda_pkg::*;

  logic [ALU_W:0] diff;
  logic [ALU_W:0] sum;

  assign diff    = {1'b0, req.a} - {1'b0, req.b};
  assign sum     = {1'b0, req.a} + {1'b0, req.b};
  assign rsp.res = req.sub ? diff[ALU_W-1:0] : sum[ALU_W-1:0];
  assign rsp.ge  = ~diff[ALU_W];

endmodule
`default_nettype wire
